// ===== sv/pcorr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcorr_pkg
// Shared types and default constants for the rolling Pearson correlation.
// ----------------------------------------------------------------------------
package pcorr_pkg;

  // Default values for the top-level parameters.
  localparam int MAX_WINDOW_DEF    = 256;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 14;

  // Window length register.
  localparam int         CFG_W        = 9;
  localparam logic [8:0] WINDOW_RESET = 9'd20;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_MOM,
    S_VMUL,
    S_SQRT,
    S_DIV,
    S_FIN
  } pcorr_state_t;

endpackage

// ===== sv/pcorr_ram.sv =====
// ----------------------------------------------------------------------------
// pcorr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pcorr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/rolling_pearson_correlation.sv =====
// ----------------------------------------------------------------------------
// rolling_pearson_correlation
// Each input beat is one (x, y) sample pair. Once the window of p pairs is
// full, every beat yields one Pearson coefficient in signed Q1.FRACTION_BITS,
// rounded and clipped to +-1.0, with a degenerate flag when a variance is
// zero. The block works on one pair at a time: a pair that completes a
// window passes through S_UPD, S_MOM, S_VMUL, S_SQRT, S_DIV and S_FIN,
// skipping from S_MOM to S_FIN when a window variance is zero, and a pair
// that does not yet fill the window goes from S_UPD to S_FIN. The run time
// is set by the shift-add forming of the variance product and the square
// root, each of which retires one bit per cycle, and by the one-bit-per-cycle
// divider. A finished result waits in the output register while the next
// pair is taken. The sample history lives in one RAM; the running sums are
// updated through a single shared multiplier.
// ----------------------------------------------------------------------------
module rolling_pearson_correlation
  import pcorr_pkg::*;
#(
  parameter int MAX_WINDOW    = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [CFG_W-1:0]              cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] x_sample,
  input  logic signed [SAMPLE_BITS-1:0] y_sample,
  input  logic                          last_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [FRACTION_BITS+1:0] correlation,
  output logic                          degenerate
);

  localparam int SB   = SAMPLE_BITS;
  localparam int F    = FRACTION_BITS;
  localparam int PW   = $clog2(MAX_WINDOW + 1);
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int SXW  = SB + PW;
  localparam int SQW  = 2 * SB + PW;
  localparam int MPW  = SQW + SXW;
  localparam int VW   = 2 * PW + 2 * SB - 2;
  localparam int CW   = $clog2(VW + F + 4);
  localparam int QW   = F + 2;
  localparam logic [QW-1:0] ONE = QW'(1) << F;

  // Registers.
  pcorr_state_t            state, state_next;
  logic [CFG_W-1:0]        window_length;
  logic [AW-1:0]           write_slot;
  logic [PW-1:0]           fill_count;
  logic signed [SXW-1:0]   sum_x, sum_y;
  logic signed [SQW-1:0]   sum_xy, sum_xx, sum_yy;
  logic signed [SB-1:0]    x_q, y_q;
  logic                    last_q, full_q, res_emit, res_degen;
  logic [2:0]              step;
  logic signed [MPW-1:0]   prod;
  logic signed [MPW-1:0]   acc_n, acc_x, acc_y;
  logic                    nneg;
  logic [VW-1:0]           nmag;
  logic [2*VW-1:0]         vacc, rad;
  logic [VW-1:0]           vmul_sh, root;
  logic [VW+1:0]           srem;
  logic [VW:0]             divr;
  logic [QW-1:0]           quo;
  logic [CW-1:0]           cnt;

  // Combinational signals.
  logic [PW-1:0]           p;
  logic [31:0]             wl32;
  logic                    ram_re, ram_we;
  logic [2*SB-1:0]         ram_rdata;
  logic signed [SB-1:0]    ox, oy;
  logic signed [SQW-1:0]   mul_a;
  logic signed [SXW-1:0]   mul_b;
  logic signed [MPW-1:0]   mul_p;
  logic signed [SQW-1:0]   prod_s;
  logic [PW-1:0]           fill_after;
  logic                    emit_now, mom_degen;
  logic [AW-1:0]           slot_next;
  logic [VW-1:0]           vx;
  logic [2*VW-1:0]         vacc_next;
  logic [VW+3:0]           st, trial;
  logic                    sge;
  logic [VW-1:0]           root_next;
  logic [VW+1:0]           srem_next;
  logic                    dge;
  logic [VW:0]             dsub;
  logic [QW:0]             qinc;
  logic [QW-1:0]           qr, qclip;
  logic signed [QW-1:0]    corr_val;
  logic                    load_out, fin_done;

  // Effective window length: zero acts as one, large values saturate.
  always_comb begin
    wl32 = 32'(window_length);
    if (wl32 == 32'd0) begin
      p = PW'(1);
    end else if (wl32 > 32'(MAX_WINDOW)) begin
      p = PW'(MAX_WINDOW);
    end else begin
      p = wl32[PW-1:0];
    end
  end

  // Sample history: x in the upper half, y in the lower half.
  pcorr_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata ({x_q, y_q}),
    .re    (ram_re),
    .raddr (write_slot),
    .rdata (ram_rdata)
  );

  assign ox = ram_rdata[2*SB-1:SB];
  assign oy = ram_rdata[SB-1:0];

  // Shared multiplier; its product is registered before use.
  assign mul_p  = MPW'(mul_a) * MPW'(mul_b);
  assign prod_s = SQW'(prod);

  // Window bookkeeping after this pair.
  assign fill_after = full_q ? fill_count : fill_count + PW'(1);
  assign emit_now   = 32'(fill_after) >= 32'(p);
  assign slot_next  = (32'(write_slot) + 32'd1 >= 32'(p)) ? '0 : write_slot + AW'(1);
  assign mom_degen  = (acc_x == '0) || (acc_y == '0);

  // Shift-add forming of the variance product, most significant bit first.
  assign vx        = acc_x[VW-1:0];
  assign vacc_next = {vacc[2*VW-2:0], 1'b0} + (vmul_sh[VW-1] ? (2*VW)'(vx) : '0);

  // Restoring square root, two radicand bits per step.
  always_comb begin
    st        = {srem, rad[2*VW-1:2*VW-2]};
    trial     = (VW+4)'({root, 2'b01});
    sge       = st >= trial;
    srem_next = (VW+2)'(sge ? st - trial : st);
    root_next = {root[VW-2:0], sge};
  end

  // Restoring division of the numerator magnitude by the root.
  always_comb begin
    dge  = divr >= {1'b0, root};
    dsub = dge ? divr - {1'b0, root} : divr;
  end

  // Rounding half up on the extra quotient bit, then clipping and sign.
  always_comb begin
    qinc  = {1'b0, quo} + (QW+1)'(1);
    qr    = qinc[QW:1];
    qclip = (qr > ONE) ? ONE : qr;
    if (res_degen) begin
      corr_val = '0;
    end else begin
      corr_val = nneg ? -$signed(qclip) : $signed(qclip);
    end
  end

  assign load_out = (state == S_FIN) && res_emit && (!out_valid || !out_stall);
  assign fin_done = (state == S_FIN) && (!res_emit || !out_valid || !out_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_UPD;
      S_UPD:  if (step == 3'd6) state_next = emit_now ? S_MOM : S_FIN;
      S_MOM:  if (step == 3'd7) state_next = mom_degen ? S_FIN : S_VMUL;
      S_VMUL: if (cnt == CW'(VW - 1)) state_next = S_SQRT;
      S_SQRT: if (cnt == CW'(VW - 1)) state_next = S_DIV;
      S_DIV:  if (cnt == CW'(QW - 1)) state_next = S_FIN;
      S_FIN:  if (fin_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs: handshake, memory controls and multiplier operands.
  always_comb begin
    in_stall = 1'b1;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        ram_re   = in_valid;
      end
      S_UPD: begin
        ram_we = (step == 3'd0);
        case (step)
          3'd0: begin mul_a = SQW'(x_q); mul_b = SXW'(y_q); end
          3'd1: begin mul_a = SQW'(x_q); mul_b = SXW'(x_q); end
          3'd2: begin mul_a = SQW'(y_q); mul_b = SXW'(y_q); end
          3'd3: begin mul_a = SQW'(ox);  mul_b = SXW'(oy);  end
          3'd4: begin mul_a = SQW'(ox);  mul_b = SXW'(ox);  end
          3'd5: begin mul_a = SQW'(oy);  mul_b = SXW'(oy);  end
          default: begin end
        endcase
      end
      S_MOM: begin
        case (step)
          3'd0: begin mul_a = sum_xy;       mul_b = SXW'({1'b0, p}); end
          3'd1: begin mul_a = SQW'(sum_x);  mul_b = sum_y;           end
          3'd2: begin mul_a = sum_xx;       mul_b = SXW'({1'b0, p}); end
          3'd3: begin mul_a = SQW'(sum_x);  mul_b = sum_x;           end
          3'd4: begin mul_a = sum_yy;       mul_b = SXW'({1'b0, p}); end
          3'd5: begin mul_a = SQW'(sum_y);  mul_b = sum_y;           end
          default: begin end
        endcase
      end
      default: begin end
    endcase
  end

  // Sequencer registers and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      window_length <= WINDOW_RESET;
      write_slot    <= '0;
      fill_count    <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xy        <= '0;
      sum_xx        <= '0;
      sum_yy        <= '0;
      step          <= '0;
      cnt           <= '0;
      res_emit      <= 1'b0;
      res_degen     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      prod  <= mul_p;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_q    <= x_sample;
            y_q    <= y_sample;
            last_q <= last_sample;
            full_q <= 32'(fill_count) >= 32'(p);
            step   <= '0;
          end
        end
        S_UPD: begin
          step <= step + 3'd1;
          // The old pair leaves the sums only once the window is full.
          if (step == 3'd0) begin
            sum_x <= sum_x + SXW'(x_q) - (full_q ? SXW'(ox) : '0);
            sum_y <= sum_y + SXW'(y_q) - (full_q ? SXW'(oy) : '0);
          end
          case (step)
            3'd1: sum_xy <= sum_xy + prod_s;
            3'd2: sum_xx <= sum_xx + prod_s;
            3'd3: sum_yy <= sum_yy + prod_s;
            3'd4: if (full_q) sum_xy <= sum_xy - prod_s;
            3'd5: if (full_q) sum_xx <= sum_xx - prod_s;
            3'd6: if (full_q) sum_yy <= sum_yy - prod_s;
            default: begin end
          endcase
          if (step == 3'd6) begin
            fill_count <= fill_after;
            write_slot <= slot_next;
            res_emit   <= emit_now;
            step       <= '0;
          end
        end
        S_MOM: begin
          step <= step + 3'd1;
          case (step)
            3'd1: acc_n <= prod;
            3'd2: acc_n <= acc_n - prod;
            3'd3: acc_x <= prod;
            3'd4: acc_x <= acc_x - prod;
            3'd5: acc_y <= prod;
            3'd6: acc_y <= acc_y - prod;
            3'd7: begin
              res_degen <= mom_degen;
              nneg      <= acc_n < 0;
              nmag      <= VW'((acc_n < 0) ? -acc_n : acc_n);
              vacc      <= '0;
              vmul_sh   <= acc_y[VW-1:0];
              cnt       <= '0;
            end
            default: begin end
          endcase
        end
        S_VMUL: begin
          vacc    <= vacc_next;
          vmul_sh <= {vmul_sh[VW-2:0], 1'b0};
          cnt     <= cnt + CW'(1);
          if (cnt == CW'(VW - 1)) begin
            rad  <= vacc_next;
            root <= '0;
            srem <= '0;
            cnt  <= '0;
          end
        end
        S_SQRT: begin
          srem <= srem_next;
          root <= root_next;
          rad  <= {rad[2*VW-3:0], 2'b00};
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(VW - 1)) begin
            divr <= {1'b0, nmag};
            quo  <= '0;
            cnt  <= '0;
          end
        end
        S_DIV: begin
          divr <= {dsub[VW-1:0], 1'b0};
          quo  <= {quo[QW-2:0], dge};
          cnt  <= cnt + CW'(1);
        end
        S_FIN: begin
          // A series end starts a fresh window after its last result.
          if (fin_done && last_q) begin
            write_slot <= '0;
            fill_count <= '0;
            sum_x      <= '0;
            sum_y      <= '0;
            sum_xy     <= '0;
            sum_xx     <= '0;
            sum_yy     <= '0;
          end
        end
        default: begin end
      endcase

      // Output register: a finished beat waits here while work goes on.
      if (load_out) begin
        out_valid   <= 1'b1;
        correlation <= corr_val;
        degenerate  <= res_degen;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      // A register write restarts the window.
      if (cfg_wr_en) begin
        window_length <= cfg_wr_data;
        write_slot    <= '0;
        fill_count    <= '0;
        sum_x         <= '0;
        sum_y         <= '0;
        sum_xy        <= '0;
        sum_xx        <= '0;
        sum_yy        <= '0;
      end
    end
  end

`ifndef SYNTH
  // The write slot always stays inside the current window.
  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    32'(write_slot) < 32'(p))
    else $error("write slot outside the window");

  // The fill count never exceeds the window length.
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) <= 32'(p))
    else $error("fill count beyond the window length");

  // A pending result is not overwritten while the output is stalled.
  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && res_emit && out_valid && out_stall) |=> (state == S_FIN))
    else $error("result left the sequencer while the output was stalled");

  // The coefficient never leaves the range of plus or minus one.
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (correlation <= $signed({1'b0, ONE}) &&
                   correlation >= -$signed({1'b0, ONE})))
    else $error("correlation outside plus or minus one");

  // A degenerate window always reports a zero coefficient.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (correlation == '0))
    else $error("degenerate result with a non-zero coefficient");
`endif

endmodule
